FILE: hdl/usmg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usmg_pkg
// shared types, constants and tables of the uv sphere mesh generator
// ----------------------------------------------------------------------------
package usmg_pkg;

    localparam int DEF_MAX_DENSITY     = 64;
    localparam int DEF_COORD_FRAC_BITS = 8;
    localparam int DEF_ANGLE_BITS      = 16;

    localparam int CORDIC_ITERS = 24;
    localparam int ITER_W       = 5;
    localparam int DENS_W       = 7;
    localparam int RAD_W        = 16;
    localparam int COORD_W      = 17;
    localparam int IDX_W        = 12;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_DENSITY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS  = 1'b1;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

    // mesh walk phases
    typedef enum logic [1:0] {
        PH_RING = 2'd0,
        PH_POLE = 2'd1,
        PH_CAP  = 2'd2,
        PH_BAND = 2'd3
    } t_phase;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHI_DIV,
        ST_PHI_CORDIC,
        ST_TH_DIV,
        ST_TH_CORDIC,
        ST_MUL_R,
        ST_MUL_Y,
        ST_MUL_X,
        ST_MUL_Z,
        ST_OUT
    } t_state;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_DIV_PHI,
        CMD_DIV_TH,
        CMD_DIV_STEP,
        CMD_CORDIC_INIT,
        CMD_CORDIC_STEP,
        CMD_STORE_PHI,
        CMD_MUL_R,
        CMD_MUL_Y,
        CMD_MUL_X,
        CMD_MUL_Z
    } t_cmd;

    typedef struct packed {
        t_cmd            cmd;
        logic            cordic_first;
    } t_ctl;

    typedef struct packed {
        logic div_done;
        logic cordic_done;
    } t_sts;

    // cordic arctangent table in 2^-32 turns
    function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] k);
        logic [31:0] v;
        unique case (k)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/usmg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usmg_datapath
// angle division, shared cordic and coordinate multiplies for ring vertices
// ----------------------------------------------------------------------------
module usmg_datapath #(
    parameter int ANGLE_BITS = usmg_pkg::DEF_ANGLE_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire usmg_pkg::t_ctl                   i_ctl,
    input  wire logic [5+1:0]                     i_ring,
    input  wire logic [5+1:0]                     i_col,
    input  wire logic [usmg_pkg::DENS_W-1:0]      i_dens,
    input  wire logic [usmg_pkg::RAD_W-1:0]       i_radius,
    output usmg_pkg::t_sts                        o_sts,
    output logic signed [usmg_pkg::COORD_W-1:0]   o_x,
    output logic signed [usmg_pkg::COORD_W-1:0]   o_y,
    output logic signed [usmg_pkg::COORD_W-1:0]   o_z
);
    import usmg_pkg::*;

    // dividend is at most (k*2^(A+1) + d), under 2^(A+9) for 7-bit k and d, so A+10 bits is enough
    localparam int NUM_W = ANGLE_BITS + 10;
    localparam int QW    = ANGLE_BITS + 1;

    logic [NUM_W-1:0]      r_num;
    logic [NUM_W-1:0]      r_rem;
    logic [QW-1:0]         r_quo;
    logic [4:0]            r_dcnt;
    logic [DENS_W:0]       r_den;

    logic signed [33:0]    r_cx, r_cy, r_cz;
    logic [1:0]            r_quad;
    logic [ITER_W-1:0]     r_k;
    logic signed [33:0]    r_cp, r_sp, r_ct, r_st;
    logic [RAD_W-1:0]      r_rr;
    logic signed [COORD_W-1:0] r_x, r_y, r_z;

    logic signed [33:0]    w_cos, w_sin, w_ux, w_uy;
    logic [31:0]           w_t;
    logic [NUM_W-1:0]      w_num_phi, w_num_th;

    // dividends of the two angle divisions
    assign w_num_phi = (NUM_W'(i_ring) << ANGLE_BITS) + NUM_W'(i_dens);
    assign w_num_th  = (NUM_W'(i_col) << (ANGLE_BITS + 1)) + NUM_W'(i_dens);

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else begin
            priority case (i_ctl.cmd)
                CMD_DIV_PHI, CMD_DIV_TH: begin
                    r_dcnt <= 5'(QW);
                end
                CMD_DIV_STEP: begin
                    if (r_dcnt != 0) r_dcnt <= r_dcnt - 5'd1;
                end
                default: ;
            endcase
        end
    end

    logic [NUM_W-1:0] w_trial;
    logic [NUM_W-1:0] w_den_ext;
    assign w_trial   = {r_rem[NUM_W-2:0], r_num[NUM_W-1]};
    assign w_den_ext = NUM_W'({r_den, 1'b0});

    // high dividend bits preload the remainder, low bits shift in
    always_ff @(posedge i_clk) begin
        priority case (i_ctl.cmd)
            CMD_DIV_PHI: begin
                r_num <= w_num_phi << (NUM_W - QW);
                r_rem <= w_num_phi >> QW;
                r_den <= (DENS_W+1)'(i_dens);
                r_quo <= '0;
            end
            CMD_DIV_TH: begin
                r_num <= w_num_th << (NUM_W - QW);
                r_rem <= w_num_th >> QW;
                r_den <= (DENS_W+1)'(i_dens);
                r_quo <= '0;
            end
            CMD_DIV_STEP: begin
                if (r_dcnt != 0) begin
                    r_num <= r_num << 1;
                    if (w_trial >= w_den_ext) begin
                        r_rem <= w_trial - w_den_ext;
                        r_quo <= {r_quo[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_quo <= {r_quo[QW-2:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_sts = t_sts'({(r_dcnt == 5'd0), (r_k == ITER_W'(CORDIC_ITERS))});

    // cordic rotation, one iteration a cycle
    assign w_t = 32'(r_quo[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);

    function automatic logic signed [33:0] clampu(input logic signed [33:0] v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < -ONE_Q30) return -ONE_Q30;
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= ITER_W'(CORDIC_ITERS);
        end else begin
            priority case (i_ctl.cmd)
                CMD_CORDIC_INIT: begin
                    r_k    <= '0;
                    r_quad <= w_t[31:30];
                    r_cx   <= CORDIC_GAIN;
                    r_cy   <= '0;
                    r_cz   <= 34'(w_t[29:0]);
                end
                CMD_CORDIC_STEP: begin
                    if (r_k != ITER_W'(CORDIC_ITERS)) begin
                        if (!r_cz[33]) begin
                            r_cx <= r_cx - (r_cy >>> r_k);
                            r_cy <= r_cy + (r_cx >>> r_k);
                            r_cz <= r_cz - 34'(atan_turn(r_k));
                        end else begin
                            r_cx <= r_cx + (r_cy >>> r_k);
                            r_cy <= r_cy - (r_cx >>> r_k);
                            r_cz <= r_cz + 34'(atan_turn(r_k));
                        end
                        r_k <= r_k + ITER_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // quadrant fold of the clamped result
    assign w_ux = clampu(r_cx);
    assign w_uy = clampu(r_cy);
    always_comb begin
        unique case (r_quad)
            2'd0: begin w_cos = w_ux;  w_sin = w_uy;  end
            2'd1: begin w_cos = -w_uy; w_sin = w_ux;  end
            2'd2: begin w_cos = -w_ux; w_sin = -w_uy; end
            default: begin w_cos = w_uy; w_sin = -w_ux; end
        endcase
    end

    // rounded magnitude times q4.30 unit, one multiply per cycle
    function automatic logic signed [COORD_W-1:0] scale(
        input logic [RAD_W-1:0] mag, input logic signed [33:0] u);
        logic        neg;
        logic [30:0] au;
        logic [47:0] p;
        logic [17:0] q;
        neg = u[33];
        au  = neg ? 31'(-u) : 31'(u);
        p   = 48'(mag) * 48'(au) + 48'(1 << 29);
        q   = 18'(p >> 30);
        return neg ? COORD_W'(-$signed(q)) : COORD_W'($signed(q));
    endfunction

    logic signed [COORD_W-1:0] w_prod;
    always_comb begin
        priority case (i_ctl.cmd)
            CMD_MUL_R: w_prod = scale(i_radius, r_sp);
            CMD_MUL_Y: w_prod = scale(i_radius, r_cp);
            CMD_MUL_X: w_prod = scale(r_rr, r_ct);
            default:   w_prod = scale(r_rr, r_st);
        endcase
    end

    always_ff @(posedge i_clk) begin
        priority case (i_ctl.cmd)
            CMD_STORE_PHI: begin
                if (i_ctl.cordic_first) begin
                    r_cp <= w_cos; r_sp <= w_sin;
                end else begin
                    r_ct <= w_cos; r_st <= w_sin;
                end
            end
            CMD_MUL_R: r_rr <= w_prod[COORD_W-1] ? '0 : RAD_W'(w_prod);
            CMD_MUL_Y: r_y  <= w_prod;
            CMD_MUL_X: r_x  <= w_prod;
            CMD_MUL_Z: r_z  <= w_prod;
            default: ;
        endcase
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
`default_nettype wire

FILE: hdl/usmg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usmg_ctrl
// mesh walk counters and sequencer for the vertex datapath
// ----------------------------------------------------------------------------
module usmg_ctrl #(
    parameter int MAX_DENSITY = usmg_pkg::DEF_MAX_DENSITY
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_restart,
    input  wire logic                           i_out_stall,
    output logic                                o_valid,
    input  wire logic [usmg_pkg::DENS_W-1:0]    i_mesh_density,
    input  wire usmg_pkg::t_sts                 i_sts,
    output usmg_pkg::t_ctl                      o_ctl,
    output logic [6:0]                          o_ring,
    output logic [6:0]                          o_col,
    output logic [usmg_pkg::DENS_W-1:0]         o_dens,
    output logic                                o_kind,
    output logic                                o_vtx,
    output logic                                o_pole_top,
    output logic [usmg_pkg::IDX_W-1:0]          o_a,
    output logic [usmg_pkg::IDX_W-1:0]          o_b,
    output logic [usmg_pkg::IDX_W-1:0]          o_c,
    output logic                                o_last
);
    import usmg_pkg::*;

    localparam int CW = 9;

    t_state r_state, n_state;
    t_phase r_phase;
    logic [CW-1:0] r_ring, r_col;
    logic r_second;
    logic [CW-1:0] w_d;
    logic r_kind, r_vtx, r_top, r_last;
    logic [IDX_W-1:0] r_a, r_b, r_c;
    logic [6:0] r_vring, r_vcol;
    logic w_acc;

    // clamp density
    always_comb begin
        if (i_mesh_density < 7'd2) w_d = CW'(2);
        else if (CW'(i_mesh_density) > CW'(MAX_DENSITY)) w_d = CW'(MAX_DENSITY);
        else w_d = CW'(i_mesh_density);
    end

    assign w_acc   = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);

    // record decode for the accepted item
    t_phase        v_ph;
    logic [CW-1:0] v_i, v_j, v_jn, n_ring, n_col;
    logic          v_sec, n_second;
    logic          d_kind, d_vtx, d_top, d_last;
    logic [23:0]   d_a, d_b, d_c, bot, t0, t1;
    t_phase        n_ph;
    always_comb begin
        v_ph  = i_restart ? PH_RING : r_phase;
        v_i   = i_restart ? CW'(1) : r_ring;
        v_j   = i_restart ? '0 : r_col;
        v_sec = i_restart ? 1'b0 : r_second;
        if (v_ph == PH_RING && (v_i < 1 || v_i > w_d - 1 || v_j >= w_d)) begin
            v_ph = PH_POLE; v_j = '0;
        end
        if (v_ph == PH_POLE && v_j > 1) begin
            v_ph = PH_CAP; v_j = '0; v_sec = 1'b0;
        end
        if (v_ph == PH_CAP && v_j >= w_d) begin
            v_ph = PH_BAND; v_i = CW'(1); v_j = '0; v_sec = 1'b0;
        end
        if (v_ph == PH_BAND && (v_i < 1 || v_i > w_d - 2 || v_j >= w_d)) begin
            v_ph = PH_RING; v_i = CW'(1); v_j = '0; v_sec = 1'b0;
        end
        v_jn = (v_j + CW'(1) >= w_d) ? '0 : v_j + CW'(1);
        bot  = 24'(w_d) * 24'(w_d - 1);
        t0   = 24'(v_i - 1) * 24'(w_d);
        t1   = 24'(v_i) * 24'(w_d);
        n_ph = v_ph; n_ring = v_i; n_col = v_j; n_second = v_sec;
        d_kind = 1'b0; d_vtx = 1'b0; d_top = 1'b0; d_last = 1'b0;
        d_a = '0; d_b = '0; d_c = '0;
        unique case (v_ph)
            PH_RING: begin
                d_vtx = 1'b1;
                if (v_j + CW'(1) >= w_d) begin n_col = '0; n_ring = v_i + CW'(1); end
                else n_col = v_j + CW'(1);
            end
            PH_POLE: begin
                d_top = (v_j != 0);
                n_col = v_j + CW'(1);
            end
            PH_CAP: begin
                d_kind = 1'b1;
                if (!v_sec) begin
                    d_a = bot + 24'd1; d_b = 24'(v_jn); d_c = 24'(v_j); n_second = 1'b1;
                end else begin
                    d_a = bot; d_b = bot - 24'(w_d) + 24'(v_j);
                    d_c = bot - 24'(w_d) + 24'(v_jn);
                    n_second = 1'b0;
                    d_last = (w_d == 2) && (v_j == w_d - 1);
                    n_col = v_j + CW'(1);
                end
            end
            default: begin
                d_kind = 1'b1;
                if (!v_sec) begin
                    d_a = t0 + 24'(v_j); d_b = t0 + 24'(v_jn); d_c = t1 + 24'(v_j);
                    n_second = 1'b1;
                end else begin
                    d_a = t0 + 24'(v_jn); d_b = t1 + 24'(v_jn); d_c = t1 + 24'(v_j);
                    n_second = 1'b0;
                    d_last = (v_i == w_d - 2) && (v_j == w_d - 1);
                    if (v_j + CW'(1) >= w_d) begin n_col = '0; n_ring = v_i + CW'(1); end
                    else n_col = v_j + CW'(1);
                end
            end
        endcase
        if (d_last) begin
            n_ph = PH_RING; n_ring = CW'(1); n_col = '0; n_second = 1'b0;
        end
    end

    // walk state and latched record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RING; r_ring <= CW'(1); r_col <= '0; r_second <= 1'b0;
        end else if (w_acc) begin
            r_phase <= n_ph; r_ring <= n_ring; r_col <= n_col;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_kind <= d_kind; r_vtx <= d_vtx; r_top <= d_top; r_last <= d_last;
            r_a <= d_a[IDX_W-1:0]; r_b <= d_b[IDX_W-1:0]; r_c <= d_c[IDX_W-1:0];
            r_vring <= 7'(v_i); r_vcol <= 7'(v_j);
        end
    end

    // next state, unit status is ignored in the kick cycle
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (w_acc) n_state = d_vtx ? ST_PHI_DIV : ST_OUT;
            ST_PHI_DIV:    if (!r_kick && i_sts.div_done) n_state = ST_PHI_CORDIC;
            ST_PHI_CORDIC: if (!r_kick && i_sts.cordic_done) n_state = ST_TH_DIV;
            ST_TH_DIV:     if (!r_kick && i_sts.div_done) n_state = ST_TH_CORDIC;
            ST_TH_CORDIC:  if (!r_kick && i_sts.cordic_done) n_state = ST_MUL_R;
            ST_MUL_R:      n_state = ST_MUL_Y;
            ST_MUL_Y:      n_state = ST_MUL_X;
            ST_MUL_X:      n_state = ST_MUL_Z;
            ST_MUL_Z:      n_state = ST_OUT;
            ST_OUT:        if (!i_out_stall) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // commands, with first-cycle kicks on entering each unit
    logic r_kick;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_kick <= 1'b0;
        else r_kick <= (n_state != r_state);
    end

    always_comb begin
        o_ctl.cmd = CMD_NONE;
        o_ctl.cordic_first = (r_state == ST_PHI_CORDIC);
        unique case (r_state)
            ST_PHI_DIV:    o_ctl.cmd = r_kick ? CMD_DIV_PHI : CMD_DIV_STEP;
            ST_TH_DIV:     o_ctl.cmd = r_kick ? CMD_DIV_TH : CMD_DIV_STEP;
            ST_PHI_CORDIC, ST_TH_CORDIC:
                o_ctl.cmd = r_kick ? CMD_CORDIC_INIT :
                            (i_sts.cordic_done ? CMD_STORE_PHI : CMD_CORDIC_STEP);
            ST_MUL_R:      o_ctl.cmd = CMD_MUL_R;
            ST_MUL_Y:      o_ctl.cmd = CMD_MUL_Y;
            ST_MUL_X:      o_ctl.cmd = CMD_MUL_X;
            ST_MUL_Z:      o_ctl.cmd = CMD_MUL_Z;
            default:       o_ctl.cmd = CMD_NONE;
        endcase
    end

    assign o_ring     = r_vring;
    assign o_col      = r_vcol;
    assign o_dens     = DENS_W'(w_d);
    assign o_kind     = r_kind;
    assign o_vtx      = r_vtx;
    assign o_pole_top = r_top;
    assign o_a        = r_a;
    assign o_b        = r_b;
    assign o_c        = r_c;
    assign o_last     = r_last;

endmodule
`default_nettype wire

FILE: hdl/uv_sphere_mesh_generator.sv
`default_nettype none
// triangle and pole records appear in the cycle after they are accepted; ring
// vertices take an angle division and a cordic pass for each of two angles, then four multiplies
// one request at a time, a new one is taken only once the last record has left,
// and any output stall holds it; the one cordic serves both angle passes of a vertex
// reset: synchronous active low, density 8, radius 1.0, walk at first vertex
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator
// emits vertex then triangle records of a latitude-longitude sphere mesh
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator #(
    parameter int MAX_DENSITY     = usmg_pkg::DEF_MAX_DENSITY,
    parameter int COORD_FRAC_BITS = usmg_pkg::DEF_COORD_FRAC_BITS,
    parameter int ANGLE_BITS      = usmg_pkg::DEF_ANGLE_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_restart,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_record_kind,
    output logic signed [usmg_pkg::COORD_W-1:0]    o_coord_x,
    output logic signed [usmg_pkg::COORD_W-1:0]    o_coord_y,
    output logic signed [usmg_pkg::COORD_W-1:0]    o_coord_z,
    output logic [usmg_pkg::IDX_W-1:0]             o_corner_a,
    output logic [usmg_pkg::IDX_W-1:0]             o_corner_b,
    output logic [usmg_pkg::IDX_W-1:0]             o_corner_c,
    output logic                                   o_last_record,
    input  wire logic                              i_cfg_we,
    input  wire logic [usmg_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [usmg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import usmg_pkg::*;

    logic [DENS_W-1:0] r_density;
    logic [RAD_W-1:0]  r_radius;
    t_ctl w_ctl;
    t_sts w_sts;
    logic [6:0] w_ring, w_col;
    logic [DENS_W-1:0] w_dens;
    logic w_kind, w_vtx, w_top, w_last;
    logic [IDX_W-1:0] w_a, w_b, w_c;
    logic signed [COORD_W-1:0] w_x, w_y, w_z;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density <= DENS_W'(8);
            r_radius  <= RAD_W'(1 << COORD_FRAC_BITS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DENSITY: r_density <= i_cfg_data[DENS_W-1:0];
                default:     r_radius  <= i_cfg_data[RAD_W-1:0];
            endcase
        end
    end

    usmg_ctrl #(.MAX_DENSITY(MAX_DENSITY)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_restart,
        .i_out_stall(i_stall), .o_valid,
        .i_mesh_density(r_density), .i_sts(w_sts), .o_ctl(w_ctl),
        .o_ring(w_ring), .o_col(w_col), .o_dens(w_dens),
        .o_kind(w_kind), .o_vtx(w_vtx), .o_pole_top(w_top),
        .o_a(w_a), .o_b(w_b), .o_c(w_c), .o_last(w_last)
    );

    usmg_datapath #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_ctl(w_ctl), .i_ring(w_ring), .i_col(w_col),
        .i_dens(w_dens), .i_radius(r_radius), .o_sts(w_sts),
        .o_x(w_x), .o_y(w_y), .o_z(w_z)
    );

    // result mux
    always_comb begin
        o_record_kind = w_kind;
        o_corner_a = w_a; o_corner_b = w_b; o_corner_c = w_c;
        o_last_record = w_last;
        if (w_vtx) begin
            o_coord_x = w_x; o_coord_y = w_y; o_coord_z = w_z;
        end else if (!w_kind) begin
            o_coord_x = '0; o_coord_z = '0;
            o_coord_y = w_top ? COORD_W'(r_radius) : -COORD_W'(r_radius);
        end else begin
            o_coord_x = '0; o_coord_y = '0; o_coord_z = '0;
        end
    end

endmodule
`default_nettype wire
